// ----- rtl/core/segt_pkg.sv -----
package segt_pkg;

    localparam int MAX_LEAVES = 1024;
    localparam int LEAF_W     = $clog2(MAX_LEAVES);
    localparam int NODES      = 2 * MAX_LEAVES;
    localparam int NODE_AW    = $clog2(NODES);
    localparam int QRY_W      = NODE_AW + 1;
    localparam int SIZE_W     = LEAF_W + 1;
    localparam int VAL_W      = 32;
    localparam int OP_W       = 2;
    localparam int ACT_W      = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [OP_W-1:0] OP_MIN = 2'd0;
    localparam logic [OP_W-1:0] OP_MAX = 2'd1;
    localparam logic [OP_W-1:0] OP_SUM = 2'd2;

    localparam logic [ACT_W-1:0] ACT_SET   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MERGE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MERGE_OP    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE = 1'd1;

    typedef struct packed {
        logic [ACT_W-1:0]         action;
        logic [LEAF_W-1:0]        index;
        logic signed [VAL_W-1:0]  value;
        logic [LEAF_W-1:0]        range_low;
        logic [LEAF_W-1:0]        range_high;
    } t_in;

    typedef struct packed {
        logic signed [VAL_W-1:0]  result_value;
        logic                     error;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_LREAD,
        S_LEAF,
        S_UP,
        S_QUERY,
        S_QDRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_init;
        logic clr_step;
        logic fin_err;
        logic fin_empty;
        logic leaf_rd;
        logic leaf_wr;
        logic up;
        logic q_init;
        logic q_step;
        logic q_fin;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic is_merge;
        logic is_query;
        logic q_empty;
        logic at_root;
        logic q_more;
    } t_dp_stat;

    function automatic logic [VAL_W-1:0] f_identity(input logic [OP_W-1:0] op);
        logic [VAL_W-1:0] v;
        case (op)
            OP_MIN:  v = {1'b0, {(VAL_W-1){1'b1}}};
            OP_MAX:  v = {1'b1, {(VAL_W-1){1'b0}}};
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] f_combine(input logic [OP_W-1:0] op,
                                                   input logic [VAL_W-1:0] a,
                                                   input logic [VAL_W-1:0] b);
        logic [VAL_W-1:0] v;
        case (op)
            OP_MIN:  v = ($signed(a) <= $signed(b)) ? a : b;
            OP_MAX:  v = ($signed(a) >= $signed(b)) ? a : b;
            default: v = a + b;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/segt_ram.sv -----
module segt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/segt_ctrl.sv -----
module segt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  segt_pkg::t_dp_stat i_stat,
    output segt_pkg::t_dp_cmd  o_cmd,
    output logic               o_strobe
);

    import segt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_stat.bad) begin
                    n_state = S_DONE;
                end else if (i_stat.is_query) begin
                    n_state = i_stat.q_empty ? S_DONE : S_QUERY;
                end else begin
                    n_state = i_stat.is_merge ? S_LREAD : S_LEAF;
                end
            end
            S_LREAD:  n_state = S_LEAF;
            S_LEAF:   n_state = S_UP;
            S_UP: begin
                if (i_stat.at_root) n_state = S_DONE;
            end
            S_QUERY: begin
                if (!i_stat.q_more) n_state = S_QDRAIN;
            end
            S_QDRAIN: n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
        // a register write restarts the clearing pass
        if (i_cfg_we) n_state = S_CLEAR;
    end

    // outputs
    always_comb begin
        o_cmd          = '0;
        o_cmd.clr_init = i_cfg_we;
        o_strobe       = 1'b0;
        busy           = 1'b1;
        unique case (r_state)
            S_CLEAR:  o_cmd.clr_step = !i_cfg_we;
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_DECODE: begin
                if (i_stat.bad) begin
                    o_cmd.fin_err = 1'b1;
                end else if (i_stat.is_query) begin
                    o_cmd.fin_empty = i_stat.q_empty;
                    o_cmd.q_init    = !i_stat.q_empty;
                end
            end
            S_LREAD:  o_cmd.leaf_rd = 1'b1;
            S_LEAF:   o_cmd.leaf_wr = 1'b1;
            S_UP:     o_cmd.up      = 1'b1;
            S_QUERY:  o_cmd.q_step  = i_stat.q_more;
            S_QDRAIN: o_cmd.q_fin   = 1'b1;
            S_DONE:   o_strobe      = 1'b1;
            default:  busy          = 1'b1;
        endcase
    end

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start && !i_cfg_we) |=> (r_state == S_DECODE))
        else $error("accepted word did not enter decode");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == S_CLEAR))
        else $error("register write did not restart clearing");

endmodule

// ----- rtl/core/segt_dp.sv -----
module segt_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  segt_pkg::t_in                    i_item,
    input  logic                             i_cfg_we,
    input  logic [segt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [segt_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  segt_pkg::t_dp_cmd                i_cmd,
    output segt_pkg::t_dp_stat               o_stat,
    output segt_pkg::t_out                   o_result
);

    import segt_pkg::*;

    logic [OP_W-1:0]    r_op;
    logic [SIZE_W-1:0]  r_size;
    logic [NODE_AW-1:0] r_clr;
    logic               r_err;
    logic               r_pend;
    t_in                r_in;
    logic [NODE_AW-1:0] r_pos;
    logic [VAL_W-1:0]   r_cur;
    logic [VAL_W-1:0]   r_res;
    logic [QRY_W-1:0]   r_l;
    logic [QRY_W-1:0]   r_r;

    logic [SIZE_W-1:0]  w_n;
    logic [VAL_W-1:0]   w_ident;
    logic [VAL_W-1:0]   w_rdata;
    logic [VAL_W-1:0]   w_leaf;
    logic [VAL_W-1:0]   w_mix;
    logic [NODE_AW-1:0] w_par;
    logic               w_is_upd;
    logic               w_is_query;
    logic               w_q_rd_l;
    logic               w_q_rd_r;
    logic [QRY_W-1:0]   w_l1;
    logic [QRY_W-1:0]   w_r1;

    logic               w_we;
    logic [NODE_AW-1:0] w_waddr;
    logic [VAL_W-1:0]   w_wdata;
    logic               w_re;
    logic [NODE_AW-1:0] w_raddr;

    segt_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NODES)
    ) u_nodes (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_n     = (r_size > SIZE_W'(MAX_LEAVES)) ? SIZE_W'(MAX_LEAVES) : r_size;
    assign w_ident = f_identity(r_op);
    assign w_par   = r_pos >> 1;

    // leaf value for set or merge; merge reads the old leaf in the preceding S_LREAD state
    assign w_leaf = (r_in.action == ACT_MERGE) ? f_combine(r_op, w_rdata, r_in.value)
                                               : r_in.value;
    // shared merge of the running value with the word just read
    assign w_mix  = f_combine(r_op, r_cur, w_rdata);

    assign w_is_upd   = (r_in.action == ACT_SET) || (r_in.action == ACT_MERGE);
    assign w_is_query = (r_in.action == ACT_QUERY);

    // one node read per step: left boundary first, then right, shift when both even
    assign w_q_rd_l = r_l[0];
    assign w_q_rd_r = !r_l[0] && r_r[0];
    assign w_l1     = w_q_rd_l ? r_l + QRY_W'(1) : r_l;
    assign w_r1     = w_q_rd_r ? r_r - QRY_W'(1) : r_r;

    always_comb begin
        o_stat.clr_last = (r_clr == {NODE_AW{1'b1}});
        o_stat.is_merge = (r_in.action == ACT_MERGE);
        o_stat.is_query = w_is_query;
        o_stat.q_empty  = (r_in.range_low > r_in.range_high);
        o_stat.at_root  = (w_par == NODE_AW'(1));
        o_stat.q_more   = (r_l < r_r);
        if (w_is_upd) begin
            o_stat.bad = ({1'b0, r_in.index} >= w_n);
        end else if (w_is_query) begin
            o_stat.bad = !o_stat.q_empty && ({1'b0, r_in.range_high} >= w_n);
        end else begin
            o_stat.bad = 1'b1;
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = w_ident;
        w_re    = 1'b0;
        w_raddr = r_pos;
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
        end
        if (i_cmd.leaf_rd) begin
            w_re = 1'b1;
        end
        if (i_cmd.leaf_wr) begin
            w_we    = 1'b1;
            w_waddr = r_pos;
            w_wdata = w_leaf;
            w_re    = 1'b1;
            w_raddr = r_pos ^ NODE_AW'(1);
        end
        if (i_cmd.up) begin
            w_we    = 1'b1;
            w_waddr = w_par;
            w_wdata = w_mix;
            w_re    = 1'b1;
            w_raddr = w_par ^ NODE_AW'(1);
        end
        if (i_cmd.q_step) begin
            w_re    = w_q_rd_l || w_q_rd_r;
            w_raddr = w_q_rd_l ? r_l[NODE_AW-1:0] : w_r1[NODE_AW-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op   <= OP_SUM;
            r_size <= SIZE_W'(MAX_LEAVES);
            r_clr  <= '0;
            r_err  <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MERGE_OP) begin
                    r_op <= i_cfg_data[OP_W-1:0];
                end else if (i_cfg_idx == REG_SIZE_IN_USE) begin
                    r_size <= i_cfg_data[SIZE_W-1:0];
                end
            end
            if (i_cmd.clr_init) begin
                r_clr <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= r_clr + NODE_AW'(1);
            end
            if (i_cmd.load) begin
                r_err <= 1'b0;
            end else if (i_cmd.fin_err) begin
                r_err <= 1'b1;
            end
            r_pend <= i_cmd.q_step && (w_q_rd_l || w_q_rd_r);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in  <= i_item;
            r_pos <= NODE_AW'(MAX_LEAVES) + NODE_AW'(i_item.index);
        end
        if (i_cmd.fin_err) begin
            r_res <= '0;
        end
        if (i_cmd.fin_empty) begin
            r_res <= w_ident;
        end
        if (i_cmd.leaf_wr) begin
            r_cur <= w_leaf;
            r_res <= w_leaf;
        end
        if (i_cmd.up) begin
            r_cur <= w_mix;
            r_pos <= w_par;
        end
        if (i_cmd.q_init) begin
            r_cur <= w_ident;
            r_l   <= QRY_W'(MAX_LEAVES) + QRY_W'(r_in.range_low);
            r_r   <= QRY_W'(MAX_LEAVES) + QRY_W'(r_in.range_high) + QRY_W'(1);
        end
        if (r_pend) begin
            r_cur <= w_mix;
        end
        if (i_cmd.q_step) begin
            if (!w_l1[0] && !w_r1[0]) begin
                r_l <= w_l1 >> 1;
                r_r <= w_r1 >> 1;
            end else begin
                r_l <= w_l1;
                r_r <= w_r1;
            end
        end
        if (i_cmd.q_fin) begin
            r_res <= r_pend ? w_mix : r_cur;
        end
    end

    assign o_result.result_value = $signed(r_res);
    assign o_result.error        = r_err;

    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && w_re) |-> (w_waddr != w_raddr))
        else $error("node read and write collide on one address");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |-> (r_res == '0))
        else $error("error result carries a nonzero value");

    a_walk_upward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.up |=> (r_pos == $past(w_par)))
        else $error("tree walk did not move to the parent");

endmodule

// ----- rtl/core/segment_tree_range_aggregate.sv -----
// Segment tree over up to 1024 signed 32-bit leaves with a min, max or wrapping-sum merge.
// A word is taken when start is high, busy is low and no register write comes; its one
// result appears on o_result with o_strobe, high for a single cycle, and cannot be held off.
// A set writes its leaf and a merge first reads the old leaf; the walk from the leaf to the
// root then takes one step per tree level on the single-read, single-write node memory. A
// query reads its nodes one at a time on the same read port. Errors and empty ranges answer
// straight from decode. After reset and after every register write the node memory is
// cleared to the merge identity, one node per cycle, with busy high; register writes are
// taken at any time and restart that pass.
module segment_tree_range_aggregate (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  segt_pkg::t_in                    i_item,
    output logic                             o_strobe,
    output segt_pkg::t_out                   o_result,
    input  logic                             i_cfg_we,
    input  logic [segt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [segt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import segt_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    segt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cfg_we (i_cfg_we),
        .i_stat   (w_stat),
        .o_cmd    (w_cmd),
        .o_strobe (o_strobe)
    );

    segt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_result   (o_result)
    );

endmodule
